// File: src/http_chunked_body_decoder_core_assert.svh
// Assertion macros for the chunked body decoder.
// Depends on nothing; included by http_chunked_body_decoder_core, which checks its own logic.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hcbd_pkg.sv
// Shared constants and helpers for the chunked body decoder.
// No dependencies; used by http_chunked_body_decoder_core and by the bench.
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS_DEF  = 48;
    localparam int CHUNK_SIZE_W   = 48;
    localparam int CFG_W          = 4;
    localparam int PHASE_W        = 4;
    localparam int STATUS_W       = 2;

    localparam logic [CFG_W-1:0] MAX_DIGITS_RST = 4'd12;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_SIZE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DATA    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_END_CR  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_END_LF  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LAST_CR = 4'd5;
    localparam logic [PHASE_W-1:0] PH_LAST_LF = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DONE    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ERROR   = 4'd8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

    // Input operations
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit; valid is low for any other byte.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        logic [7:0] diff;
        d    = '0;
        diff = 8'd0;
        if (c inside {[CH_0:CH_9]}) begin
            diff    = c - CH_0;
            d.valid = 1'b1;
        end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
            diff    = c - CH_LA + 8'd10;
            d.valid = 1'b1;
        end else if (c inside {[CH_UA:CH_UF]}) begin
            diff    = c - CH_UA + 8'd10;
            d.valid = 1'b1;
        end
        d.value = diff[3:0];
        return d;
    endfunction

endpackage

`default_nettype wire

// File: src/http_chunked_body_decoder_core.sv
// HTTP chunked transfer body decoder, one byte per transaction.
// Depends on hcbd_pkg and http_chunked_body_decoder_core_assert.svh.
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, op, data_byte            | sink
//  out     | out_valid, out_ready, payload_valid,         | source
//          | payload_byte, chunk_end, size_ready,         |
//          | chunk_size, status                           |
//  cfg     | cfg_wr_en, cfg_wr_data (max_size_digits)     | sink
//
// One transaction per cycle sustained while out_ready is high: input
// register, combinational parse logic (hex decode, shift, decrement),
// result register. The parse state advances only when the input register
// hands its transaction to the result register, so a stall on out_ready
// backs up into in_ready without losing anything.
// rst_n clears the parse state, the valid flags and sets max_size_digits
// to 12.
`default_nettype none

`include "http_chunked_body_decoder_core_assert.svh"

module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [hcbd_pkg::CFG_W-1:0]         cfg_wr_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               op,
    input  wire logic [7:0]                         data_byte,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    payload_valid,
    output logic [7:0]                              payload_byte,
    output logic                                    chunk_end,
    output logic                                    size_ready,
    output logic [hcbd_pkg::CHUNK_SIZE_W-1:0]       chunk_size,
    output logic [hcbd_pkg::STATUS_W-1:0]           status
);

    localparam int CW = hcbd_pkg::CFG_W;
    localparam int PW = hcbd_pkg::PHASE_W;
    localparam int OW = hcbd_pkg::CHUNK_SIZE_W;
    // Most digits that fit in the size accumulator
    localparam logic [CW-1:0] DIGIT_CAP = CW'(SIZE_BITS / 4);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CW-1:0] max_digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_digits_reg <= hcbd_pkg::MAX_DIGITS_RST;
        end
        else if (cfg_wr_en)
        begin
            max_digits_reg <= cfg_wr_data;
        end
    end

    // Effective limit: zero acts as one, cap at what the accumulator holds.
    logic [CW-1:0] digit_limit;

    always_comb
    begin
        digit_limit = max_digits_reg;
        if (digit_limit == '0)
        begin
            digit_limit = CW'(1);
        end
        if (digit_limit > DIGIT_CAP)
        begin
            digit_limit = DIGIT_CAP;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds result register
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       s1_advance;
    logic       in_accept;

    // Move the held transaction forward whenever the result slot is free.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    logic [PW-1:0]        phase_reg,       phase_next;
    logic [CW-1:0]        digit_count_reg, digit_count_next;
    logic [SIZE_BITS-1:0] size_accum_reg,  size_accum_next;
    logic [SIZE_BITS-1:0] bytes_left_reg,  bytes_left_next;

    // Result fields computed for the transaction in the input register
    logic                         res_pv;
    logic [7:0]                   res_pb;
    logic                         res_ce;
    logic                         res_sr;
    logic [OW-1:0]                res_cs;
    logic [hcbd_pkg::STATUS_W-1:0] res_st;

    hcbd_pkg::hex_digit_t  hex;
    logic [SIZE_BITS-1:0]  bytes_dec;
    logic [SIZE_BITS+OW-1:0] size_ext;

    assign hex       = hcbd_pkg::hex_decode(s1_byte_reg);
    assign bytes_dec = bytes_left_reg - SIZE_BITS'(1);
    // Zero-extend or truncate the accumulator onto the fixed output width
    assign size_ext  = {{OW{1'b0}}, size_accum_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        size_accum_next  = size_accum_reg;
        bytes_left_next  = bytes_left_reg;
        res_pv = 1'b0;
        res_pb = 8'd0;
        res_ce = 1'b0;
        res_sr = 1'b0;
        res_cs = '0;
        res_st = hcbd_pkg::ST_PROGRESS;

        if (s1_op_reg == hcbd_pkg::OP_RESTART)
        begin
            phase_next       = hcbd_pkg::PH_SIZE;
            digit_count_next = '0;
            size_accum_next  = '0;
            bytes_left_next  = '0;
        end
        else
        begin
            case (phase_reg)
                hcbd_pkg::PH_SIZE:
                begin
                    if (hex.valid)
                    begin
                        if (digit_count_reg >= digit_limit)
                        begin
                            phase_next = hcbd_pkg::PH_ERROR;
                        end
                        else
                        begin
                            size_accum_next  = {size_accum_reg[SIZE_BITS-5:0], hex.value};
                            digit_count_next = digit_count_reg + CW'(1);
                        end
                    end
                    else if (s1_byte_reg == hcbd_pkg::CH_CR && digit_count_reg != '0)
                    begin
                        phase_next = hcbd_pkg::PH_SIZE_LF;
                    end
                    else
                    begin
                        phase_next = hcbd_pkg::PH_ERROR;
                    end
                end
                hcbd_pkg::PH_SIZE_LF:
                begin
                    if (s1_byte_reg == hcbd_pkg::CH_LF)
                    begin
                        res_sr           = 1'b1;
                        res_cs           = size_ext[OW-1:0];
                        bytes_left_next  = size_accum_reg;
                        phase_next       = (size_accum_reg == '0) ? hcbd_pkg::PH_LAST_CR
                                                                  : hcbd_pkg::PH_DATA;
                        size_accum_next  = '0;
                        digit_count_next = '0;
                    end
                    else
                    begin
                        phase_next = hcbd_pkg::PH_ERROR;
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    res_pv          = 1'b1;
                    res_pb          = s1_byte_reg;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                    begin
                        res_ce     = 1'b1;
                        phase_next = hcbd_pkg::PH_END_CR;
                    end
                end
                hcbd_pkg::PH_END_CR:
                begin
                    phase_next = (s1_byte_reg == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_END_LF
                                                                  : hcbd_pkg::PH_ERROR;
                end
                hcbd_pkg::PH_END_LF:
                begin
                    phase_next = (s1_byte_reg == hcbd_pkg::CH_LF) ? hcbd_pkg::PH_SIZE
                                                                  : hcbd_pkg::PH_ERROR;
                end
                hcbd_pkg::PH_LAST_CR:
                begin
                    phase_next = (s1_byte_reg == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_LAST_LF
                                                                  : hcbd_pkg::PH_ERROR;
                end
                hcbd_pkg::PH_LAST_LF:
                begin
                    if (s1_byte_reg == hcbd_pkg::CH_LF)
                    begin
                        phase_next = hcbd_pkg::PH_DONE;
                        res_st     = hcbd_pkg::ST_COMPLETE;
                    end
                    else
                    begin
                        phase_next = hcbd_pkg::PH_ERROR;
                    end
                end
                hcbd_pkg::PH_DONE:
                begin
                    res_st = hcbd_pkg::ST_IGNORED;
                end
                default:
                begin
                    // Error is sticky; unused codes fall into it too.
                    phase_next = hcbd_pkg::PH_ERROR;
                end
            endcase
            if (phase_next == hcbd_pkg::PH_ERROR)
            begin
                res_st = hcbd_pkg::ST_ERROR;
            end
        end
    end

    // Advance the parse state once per transaction handed to the result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= hcbd_pkg::PH_SIZE;
            digit_count_reg <= '0;
            size_accum_reg  <= '0;
            bytes_left_reg  <= '0;
        end
        else if (s1_advance)
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            size_accum_reg  <= size_accum_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                          pv_reg;
    logic [7:0]                    pb_reg;
    logic                          ce_reg;
    logic                          sr_reg;
    logic [OW-1:0]                 cs_reg;
    logic [hcbd_pkg::STATUS_W-1:0] st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pv_reg <= res_pv;
            pb_reg <= res_pb;
            ce_reg <= res_ce;
            sr_reg <= res_sr;
            cs_reg <= res_cs;
            st_reg <= res_st;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pb_reg;
    assign chunk_end     = ce_reg;
    assign size_ready    = sr_reg;
    assign chunk_size    = cs_reg;
    assign status        = st_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `HCBD_ASSERT_IMPLY(a_cap_digits, clk, rst_n, 1'b1, digit_count_reg <= DIGIT_CAP,
        "digit count beyond accumulator capacity")
    `HCBD_ASSERT_NEXT(a_error_sticky, clk, rst_n,
        s1_advance && s1_op_reg == hcbd_pkg::OP_BYTE && phase_reg == hcbd_pkg::PH_ERROR,
        phase_reg == hcbd_pkg::PH_ERROR, "left error without a restart")
    `HCBD_ASSERT_IMPLY(a_end_on_data, clk, rst_n, out_valid_reg && ce_reg,
        pv_reg && !sr_reg && st_reg == hcbd_pkg::ST_PROGRESS,
        "chunk end outside a data byte")
    `HCBD_ASSERT_IMPLY(a_data_nonzero, clk, rst_n, phase_reg == hcbd_pkg::PH_DATA,
        bytes_left_reg != '0, "data phase with no bytes left")
    `HCBD_ASSERT_IMPLY(a_free_slot_ready, clk, rst_n, !out_valid_reg, in_ready,
        "input stalled while result slot is empty")

endmodule

`default_nettype wire

// File: bench/chunked_decode_checker.sv
`timescale 1ns / 1ps
// Result checker for http_chunked_body_decoder_core: predicts one result per
// input transaction and compares it field by field. Depends on hcbd_pkg.
module chunked_decode_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [hcbd_pkg::CFG_W-1:0]             cfg_wr_data,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_ready,
    input  wire logic                                   op,
    input  wire logic [7:0]                             data_byte,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_ready,
    input  wire logic                                   payload_valid,
    input  wire logic [7:0]                             payload_byte,
    input  wire logic                                   chunk_end,
    input  wire logic                                   size_ready,
    input  wire logic [hcbd_pkg::CHUNK_SIZE_W-1:0]      chunk_size,
    input  wire logic [hcbd_pkg::STATUS_W-1:0]          status,
    output int unsigned                                 fail_count,
    output int unsigned                                 pending
);

    localparam logic [3:0] DIGIT_CAP = 4'(hcbd_pkg::SIZE_BITS_DEF / 4);

    typedef struct packed {
        logic                                payload_valid;
        logic [7:0]                          payload_byte;
        logic                                chunk_end;
        logic                                size_ready;
        logic [hcbd_pkg::CHUNK_SIZE_W-1:0]   chunk_size;
        logic [hcbd_pkg::STATUS_W-1:0]       status;
    } chunk_result_t;

    // Decoder state as the block should hold it
    logic [hcbd_pkg::CFG_W-1:0]         digit_limit_cfg;
    logic [hcbd_pkg::PHASE_W-1:0]       parse_phase;
    logic [3:0]                         digits_seen;
    logic [hcbd_pkg::SIZE_BITS_DEF-1:0] size_acc;
    logic [hcbd_pkg::SIZE_BITS_DEF-1:0] bytes_remaining;

    chunk_result_t expected_results[$];

    task automatic clear_message();
        parse_phase     = hcbd_pkg::PH_SIZE;
        digits_seen     = 4'd0;
        size_acc        = '0;
        bytes_remaining = '0;
    endtask

    // Advance the parse state by one byte and return the result it causes.
    task automatic decode_step(input logic op_v, input logic [7:0] b,
                               output chunk_result_t r);
        logic       is_hex;
        logic [3:0] nib;
        logic [3:0] lim;
        r      = '0;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (b >= hcbd_pkg::CH_0 && b <= hcbd_pkg::CH_9)
            nib = 4'(b - hcbd_pkg::CH_0);
        else if (b >= hcbd_pkg::CH_LA && b <= hcbd_pkg::CH_LF_HEX)
            nib = 4'(b - hcbd_pkg::CH_LA + 8'd10);
        else if (b >= hcbd_pkg::CH_UA && b <= hcbd_pkg::CH_UF)
            nib = 4'(b - hcbd_pkg::CH_UA + 8'd10);
        else
            is_hex = 1'b0;
        lim = (digit_limit_cfg == '0) ? 4'd1 : digit_limit_cfg;
        if (lim > DIGIT_CAP)
            lim = DIGIT_CAP;

        if (op_v == hcbd_pkg::OP_RESTART)
        begin
            clear_message();
        end
        else
        begin
            case (parse_phase)
                hcbd_pkg::PH_SIZE:
                begin
                    if (is_hex)
                    begin
                        if (digits_seen >= lim)
                        begin
                            parse_phase = hcbd_pkg::PH_ERROR;
                        end
                        else
                        begin
                            size_acc    = {size_acc[hcbd_pkg::SIZE_BITS_DEF-5:0], nib};
                            digits_seen = digits_seen + 4'd1;
                        end
                    end
                    else if (b == hcbd_pkg::CH_CR && digits_seen != 4'd0)
                    begin
                        parse_phase = hcbd_pkg::PH_SIZE_LF;
                    end
                    else
                    begin
                        parse_phase = hcbd_pkg::PH_ERROR;
                    end
                end
                hcbd_pkg::PH_SIZE_LF:
                begin
                    if (b == hcbd_pkg::CH_LF)
                    begin
                        r.size_ready    = 1'b1;
                        r.chunk_size    = size_acc[hcbd_pkg::CHUNK_SIZE_W-1:0];
                        bytes_remaining = size_acc;
                        parse_phase     = (size_acc == '0) ? hcbd_pkg::PH_LAST_CR
                                                           : hcbd_pkg::PH_DATA;
                        size_acc        = '0;
                        digits_seen     = 4'd0;
                    end
                    else
                    begin
                        parse_phase = hcbd_pkg::PH_ERROR;
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    bytes_remaining = bytes_remaining - 1'b1;
                    if (bytes_remaining == '0)
                    begin
                        r.chunk_end = 1'b1;
                        parse_phase = hcbd_pkg::PH_END_CR;
                    end
                end
                hcbd_pkg::PH_END_CR:
                    parse_phase = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_END_LF
                                                         : hcbd_pkg::PH_ERROR;
                hcbd_pkg::PH_END_LF:
                    parse_phase = (b == hcbd_pkg::CH_LF) ? hcbd_pkg::PH_SIZE
                                                         : hcbd_pkg::PH_ERROR;
                hcbd_pkg::PH_LAST_CR:
                    parse_phase = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_LAST_LF
                                                         : hcbd_pkg::PH_ERROR;
                hcbd_pkg::PH_LAST_LF:
                begin
                    if (b == hcbd_pkg::CH_LF)
                    begin
                        parse_phase = hcbd_pkg::PH_DONE;
                        r.status    = hcbd_pkg::ST_COMPLETE;
                    end
                    else
                    begin
                        parse_phase = hcbd_pkg::PH_ERROR;
                    end
                end
                hcbd_pkg::PH_DONE:
                    r.status = hcbd_pkg::ST_IGNORED;
                default:
                    parse_phase = hcbd_pkg::PH_ERROR;
            endcase
            if (parse_phase == hcbd_pkg::PH_ERROR)
                r.status = hcbd_pkg::ST_ERROR;
        end
    endtask

    task automatic compare_field(input string field, input logic [47:0] want,
                                 input logic [47:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h actual %0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        chunk_result_t want;
        chunk_result_t got;
        if (!rst_n)
        begin
            digit_limit_cfg = hcbd_pkg::MAX_DIGITS_RST;
            clear_message();
            expected_results.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                digit_limit_cfg = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                decode_step(op, data_byte, want);
                expected_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = {payload_valid, payload_byte, chunk_end, size_ready,
                       chunk_size, status};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none actual %h",
                             $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("payload_valid", 48'(want.payload_valid),
                                  48'(got.payload_valid));
                    compare_field("payload_byte", 48'(want.payload_byte),
                                  48'(got.payload_byte));
                    compare_field("chunk_end", 48'(want.chunk_end),
                                  48'(got.chunk_end));
                    compare_field("size_ready", 48'(want.size_ready),
                                  48'(got.size_ready));
                    compare_field("chunk_size", want.chunk_size, got.chunk_size);
                    compare_field("status", 48'(want.status), 48'(got.status));
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

// File: bench/http_chunked_body_decoder_core_tb.sv
`timescale 1ns / 1ps
// Regression top for http_chunked_body_decoder_core: clock, reset, stimulus,
// flow control and verdict. Depends on hcbd_pkg and chunked_decode_checker.
module http_chunked_body_decoder_core_tb;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int MAX_GAP         = 16;

    logic                              clk;
    logic                              rst_n       = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [hcbd_pkg::CFG_W-1:0]        cfg_wr_data = '0;
    logic                              in_valid    = 1'b0;
    logic                              in_ready;
    logic                              op          = hcbd_pkg::OP_BYTE;
    logic [7:0]                        data_byte   = 8'h00;
    logic                              out_valid;
    logic                              out_ready   = 1'b0;
    logic                              payload_valid;
    logic [7:0]                        payload_byte;
    logic                              chunk_end;
    logic                              size_ready;
    logic [hcbd_pkg::CHUNK_SIZE_W-1:0] chunk_size;
    logic [hcbd_pkg::STATUS_W-1:0]     status;

    int unsigned fail_count;
    int unsigned pending;

    // Flow control knobs for the sender and the receiver
    int unsigned tx_max_gap   = MAX_GAP;
    int unsigned rx_max_gap   = MAX_GAP;
    bit          rx_hold_req  = 1'b0;
    bit          rx_hold_done = 1'b0;

    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  msg_bytes[$];

    http_chunked_body_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .chunk_end     (chunk_end),
        .size_ready    (size_ready),
        .chunk_size    (chunk_size),
        .status        (status)
    );

    chunked_decode_checker result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .chunk_end     (chunk_end),
        .size_ready    (size_ready),
        .chunk_size    (chunk_size),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run; the limit covers every byte seeing the longest gaps
    // on both sides plus the long receiver hold many times over.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("http_chunked_body_decoder_core regression: fail");
            $finish;
        end
    end

    // Offer one transaction. Call at a rising edge; returns at the edge where
    // the block takes it. Valid stays high across back-to-back transactions.
    task automatic offer_byte(input logic op_v, input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= op_v;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_byte(hcbd_pkg::OP_BYTE, s[i]);
    endtask

    // Drop valid and hold until every result has come back, then let the
    // pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Hex digit in random letter case.
    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10)
            return hcbd_pkg::CH_0 + 8'(nib);
        return (($urandom & 1) ? hcbd_pkg::CH_UA : hcbd_pkg::CH_LA) + 8'(nib) - 8'd10;
    endfunction

    // Digit count for a size line: the digits needed plus leading zeros up to
    // the limit, and now and then one digit past the limit.
    function automatic int unsigned pick_digits(input logic [47:0] size_v,
                                                input int unsigned eff);
        int unsigned need;
        need = 1;
        while (need < 12 && (size_v >> (need * 4)) != 0)
            need++;
        if ($urandom_range(0, 99) < 8)
            return eff + 1;
        return $urandom_range(need, eff);
    endfunction

    task automatic add_size_line(input logic [47:0] size_v, input int unsigned ndig);
        logic [3:0] nib;
        for (int i = int'(ndig) - 1; i >= 0; i--)
        begin
            nib = (i < 12) ? size_v[i*4 +: 4] : 4'd0;
            msg_bytes.push_back(ascii_hex(nib));
        end
        msg_bytes.push_back(hcbd_pkg::CH_CR);
        msg_bytes.push_back(hcbd_pkg::CH_LF);
    endtask

    // Receiver: draw a stall before every result; on request, hold off for a
    // long stretch so the block backs up into its input.
    initial
    begin : result_sink
        int unsigned gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold_req && !rx_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_done = 1'b1;
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int unsigned limit_plan[6];
        int unsigned lim;
        int unsigned eff;
        int unsigned phase_start;
        int unsigned mode;

        limit_plan    = '{1, 0, 15, 13, 0, 12};
        limit_plan[4] = $urandom_range(2, 11);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one full message at the reset limit with data extremes,
        // a byte after the end, then several ways a message can break.
        offer_text("2\r\n");
        offer_byte(hcbd_pkg::OP_BYTE, 8'h00);
        offer_byte(hcbd_pkg::OP_BYTE, 8'hFF);
        offer_text("\r\n0\r\n\r\n");
        offer_byte(hcbd_pkg::OP_BYTE, 8'h80);          // ignored after end
        offer_byte(hcbd_pkg::OP_RESTART, 8'hFF);
        offer_text("\rz");                             // empty size line, then sticky
        offer_byte(hcbd_pkg::OP_RESTART, 8'h00);
        offer_text(";");                               // extension marker is not hex
        offer_byte(hcbd_pkg::OP_RESTART, 8'h5A);
        offer_text("1\rX");                            // missing LF after size
        offer_byte(hcbd_pkg::OP_RESTART, 8'hA5);
        offer_text("1\r\nAQ");                         // missing CR after data
        offer_byte(hcbd_pkg::OP_RESTART, 8'h0D);

        for (int p = 0; p < 6; p++)
        begin
            // Write the limit only with the block drained
            wait_idle();
            lim         = limit_plan[p];
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= hcbd_pkg::CFG_W'(lim);
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            eff = (lim == 0) ? 1 : ((lim > 12) ? 12 : lim);

            // First phase: long receiver hold while the sender runs flat out
            if (p == 0)
            begin
                tx_max_gap  = 0;
                rx_hold_req = 1'b1;
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE)
            begin : message
                int unsigned chunks;
                int unsigned pick;
                logic [47:0] size_v;
                logic [47:0] mask;
                bit          cut;

                if (!rx_hold_req || rx_hold_done)
                begin
                    mode       = $urandom_range(0, 3);
                    tx_max_gap = mode[0] ? MAX_GAP : 0;
                    rx_max_gap = mode[1] ? MAX_GAP : 0;
                end

                msg_bytes.delete();
                cut  = 1'b0;
                mask = (48'd1 << (eff * 4)) - 48'd1;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // Pure noise
                    repeat ($urandom_range(3, 20))
                        msg_bytes.push_back(8'($urandom));
                end
                else
                begin
                    chunks = $urandom_range(0, 3);
                    for (int c = 0; c < int'(chunks) && !cut; c++)
                    begin
                        if ($urandom_range(0, 99) < 12)
                        begin
                            // Wide size: announce it; past 40, send a few bytes and cut off
                            size_v = 48'({$urandom, $urandom}) & mask;
                            if (size_v == '0)
                                size_v = 48'd1;
                            cut = (size_v > 48'd40);
                        end
                        else
                        begin
                            size_v = 48'($urandom_range(1, 12));
                        end
                        add_size_line(size_v, pick_digits(size_v, eff));
                        if (cut)
                        begin
                            repeat ($urandom_range(0, 5))
                                msg_bytes.push_back(8'($urandom));
                        end
                        else
                        begin
                            repeat (int'(size_v))
                                msg_bytes.push_back(8'($urandom));
                            msg_bytes.push_back(hcbd_pkg::CH_CR);
                            msg_bytes.push_back(hcbd_pkg::CH_LF);
                        end
                    end
                    if (!cut)
                    begin
                        add_size_line(48'd0, pick_digits(48'd0, eff));
                        msg_bytes.push_back(hcbd_pkg::CH_CR);
                        msg_bytes.push_back(hcbd_pkg::CH_LF);
                    end
                    // Break some messages at one random byte
                    if (pick < 28)
                        msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
                    if ($urandom_range(0, 99) < 30)
                        repeat ($urandom_range(1, 3))
                            msg_bytes.push_back(8'($urandom));
                end
                foreach (msg_bytes[i])
                    offer_byte(hcbd_pkg::OP_BYTE, msg_bytes[i]);
                offer_byte(hcbd_pkg::OP_RESTART, 8'($urandom));
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("http_chunked_body_decoder_core regression: pass");
        else
            $display("http_chunked_body_decoder_core regression: fail");
        $finish;
    end

endmodule
